// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files; only the top-level core includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, reset masked
`define ORT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, reset masked
`define ORT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ORT_ASSERT_IMP(lbl, ante, cons, msg)
`define ORT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/orot_pkg.sv =====
// shared types, constants and geometry helpers for the rectangle overlap core
`default_nettype none
package orot_pkg;

	localparam int WORD_BITS  = 32;
	localparam int COORD_BITS = 16;
	localparam int AXIS_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = COORD_BITS + AXIS_BITS;
	localparam int PROJ_BITS  = PROD_BITS + 1;
	localparam int N_LANES    = 4;
	localparam int N_STAGES   = 7;

	typedef logic [WORD_BITS-1:0]         word_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [AXIS_BITS-1:0]  axis_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [PROJ_BITS-1:0]  proj_t;

	typedef struct packed {
		coord_t y;
		coord_t x;
	} vec_t;

	typedef struct packed {
		axis_t y;
		axis_t x;
	} axis_vec_t;

	typedef vec_t      [3:0] rect_t;
	typedef axis_vec_t [1:0] axis_pair_t;
	typedef word_t     [7:0] corner_words_t;

	// geometry held after the first stage
	typedef struct packed {
		rect_t                      a;
		rect_t                      b;
		axis_vec_t [N_LANES-1:0]    axis;
	} geom_t;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic out;
	} pipe_en_t;

	// x in the low 16 bits, y in the high 16 bits; both lie inside the 32-bit word
	function automatic vec_t unpack_corner(word_t w);
		logic [2*WORD_BITS-1:0] wide;
		vec_t                   p;
		wide = {{WORD_BITS{1'b0}}, w};
		p.x  = wide[COORD_BITS-1:0];
		p.y  = wide[2*COORD_BITS-1:COORD_BITS];
		return p;
	endfunction

	// edge vectors from corner 0, zero-length edges replaced by perpendiculars
	function automatic axis_pair_t edge_pair(rect_t r);
		axis_vec_t  e0;
		axis_vec_t  e1;
		axis_pair_t res;
		e0.x = axis_t'(r[1].x) - axis_t'(r[0].x);
		e0.y = axis_t'(r[1].y) - axis_t'(r[0].y);
		e1.x = axis_t'(r[3].x) - axis_t'(r[0].x);
		e1.y = axis_t'(r[3].y) - axis_t'(r[0].y);
		if (e0 == '0) begin
			e0.x = -e1.y;
			e0.y = e1.x;
		end
		if (e1 == '0) begin
			e1.x = e0.y;
			e1.y = -e0.x;
		end
		res[0] = e0;
		res[1] = e1;
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/orot_if.sv =====
// handshake interfaces for the rectangle pair words and the result words
`default_nettype none
interface orot_in_if;
	logic                 valid;
	logic                 ready;
	orot_pkg::word_t      a_corner0;
	orot_pkg::word_t      a_corner1;
	orot_pkg::word_t      a_corner2;
	orot_pkg::word_t      a_corner3;
	orot_pkg::word_t      b_corner0;
	orot_pkg::word_t      b_corner1;
	orot_pkg::word_t      b_corner2;
	orot_pkg::word_t      b_corner3;

	modport source (
		output valid, a_corner0, a_corner1, a_corner2, a_corner3,
		output b_corner0, b_corner1, b_corner2, b_corner3,
		input  ready
	);
	modport sink (
		input  valid, a_corner0, a_corner1, a_corner2, a_corner3,
		input  b_corner0, b_corner1, b_corner2, b_corner3,
		output ready
	);
endinterface

interface orot_out_if;
	logic valid;
	logic ready;
	logic collides;

	modport source (output valid, collides, input ready);
	modport sink (input valid, collides, output ready);
endinterface
`default_nettype wire

// ===== rtl/orot_axes.sv =====
// first stage: unpack corners and form the four candidate axes
`default_nettype none
module orot_axes (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire orot_pkg::corner_words_t words,
	output orot_pkg::geom_t              geom_s1
);

	orot_pkg::rect_t      rect_a;
	orot_pkg::rect_t      rect_b;
	orot_pkg::axis_pair_t pair_a;
	orot_pkg::axis_pair_t pair_b;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			rect_a[j] = orot_pkg::unpack_corner(words[j]);
			rect_b[j] = orot_pkg::unpack_corner(words[j+4]);
		end
		pair_a = orot_pkg::edge_pair(rect_a);
		pair_b = orot_pkg::edge_pair(rect_b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geom_s1.a       <= rect_a;
			geom_s1.b       <= rect_b;
			geom_s1.axis[0] <= pair_a[0];
			geom_s1.axis[1] <= pair_a[1];
			geom_s1.axis[2] <= pair_b[0];
			geom_s1.axis[3] <= pair_b[1];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/orot_lane.sv =====
// one axis lane: project eight corners, find both intervals, test overlap
`default_nettype none
module orot_lane (
	input  wire logic                clk,
	input  wire orot_pkg::pipe_en_t  en,
	input  wire orot_pkg::geom_t     geom_s1,
	input  wire orot_pkg::axis_vec_t axis_s1,
	output logic                     hit_s6
);

	orot_pkg::vec_t  cor [8];
	orot_pkg::prod_t px_s2 [8];
	orot_pkg::prod_t py_s2 [8];
	orot_pkg::proj_t proj_s3 [8];
	orot_pkg::proj_t lo_s4 [4];
	orot_pkg::proj_t hi_s4 [4];
	orot_pkg::proj_t lo_s5 [2];
	orot_pkg::proj_t hi_s5 [2];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			cor[j]   = geom_s1.a[j];
			cor[j+4] = geom_s1.b[j];
		end
	end

	// one multiplier per coordinate
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int j = 0; j < 8; j++) begin
				px_s2[j] <= orot_pkg::prod_t'(cor[j].x) * orot_pkg::prod_t'(axis_s1.x);
				py_s2[j] <= orot_pkg::prod_t'(cor[j].y) * orot_pkg::prod_t'(axis_s1.y);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int j = 0; j < 8; j++) begin
				proj_s3[j] <= orot_pkg::proj_t'(px_s2[j]) + orot_pkg::proj_t'(py_s2[j]);
			end
		end
	end

	// pairs 0,1 belong to the first rectangle, 2,3 to the second
	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int k = 0; k < 4; k++) begin
				lo_s4[k] <= (proj_s3[2*k+1] < proj_s3[2*k]) ? proj_s3[2*k+1] : proj_s3[2*k];
				hi_s4[k] <= (proj_s3[2*k] < proj_s3[2*k+1]) ? proj_s3[2*k+1] : proj_s3[2*k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			for (int r = 0; r < 2; r++) begin
				lo_s5[r] <= (lo_s4[2*r+1] < lo_s4[2*r]) ? lo_s4[2*r+1] : lo_s4[2*r];
				hi_s5[r] <= (hi_s4[2*r] < hi_s4[2*r+1]) ? hi_s4[2*r+1] : hi_s4[2*r];
			end
		end
	end

	// strict overlap, containment included
	always_ff @(posedge clk) begin
		if (en.s6) begin
			hit_s6 <= (lo_s5[0] < hi_s5[1]) && (lo_s5[1] < hi_s5[0]);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/orot_merge.sv =====
// merge stage: combine lane verdicts into the result register
`default_nettype none
module orot_merge (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [orot_pkg::N_LANES-1:0]  hits,
	output logic                               collides_q
);

	// a collision needs overlap on every axis
	always_ff @(posedge clk) begin
		if (en) begin
			collides_q <= &hits;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/oriented_rect_overlap_test_core.sv =====
// Oriented rectangle overlap core (separating axis test). Each input word
// carries four corners of rectangle A and of rectangle B, packed {y,x} as
// signed Q12.4. Edges corner1-corner0 and corner3-corner0 of each rectangle
// give four axes (a zero-length edge is replaced by the perpendicular of the
// other edge); all eight corners are projected exactly onto each axis and a
// collision is reported only if the intervals overlap strictly on all four.
// Throughput is one word per cycle while the result side keeps taking words:
// four lanes, one per axis, each with sixteen 16x17 multipliers, work side by
// side. Seven registered stages lie between acceptance and the result word:
// axes, products, sums, two min/max levels, overlap compare, then the merge
// register that drives the output. Every stage has its own valid bit and
// loads whenever it is empty or its successor moves, so bubbles collapse and
// a waiting result does not stop new words from entering until all seven
// stages are full. No clearing pass is needed after reset.
`default_nettype none
`include "assert_macros.svh"
module oriented_rect_overlap_test_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	orot_in_if.sink    req,
	orot_out_if.source rsp
);

	localparam int NS = orot_pkg::N_STAGES;

	// valid bit per stage, last one is the output register
	logic [NS-1:0]                 v_q;
	logic [NS-1:0]                 load;
	orot_pkg::pipe_en_t            en;
	orot_pkg::corner_words_t       words;
	orot_pkg::geom_t               geom_s1;
	logic [orot_pkg::N_LANES-1:0]  hits_s6;
	logic                          collides_q;

	// a stage loads when empty or when the stage after it moves
	always_comb begin
		load[NS-1] = !v_q[NS-1] || rsp.ready;
		for (int k = NS - 2; k >= 0; k--) begin
			load[k] = !v_q[k] || load[k+1];
		end
		en.s1  = load[0];
		en.s2  = load[1];
		en.s3  = load[2];
		en.s4  = load[3];
		en.s5  = load[4];
		en.s6  = load[5];
		en.out = load[6];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (load[0]) begin
				v_q[0] <= req.valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (load[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign req.ready = load[0];

	assign words[0] = req.a_corner0;
	assign words[1] = req.a_corner1;
	assign words[2] = req.a_corner2;
	assign words[3] = req.a_corner3;
	assign words[4] = req.b_corner0;
	assign words[5] = req.b_corner1;
	assign words[6] = req.b_corner2;
	assign words[7] = req.b_corner3;

	// axis formation
	orot_axes u_axes (
		.clk     (clk),
		.en      (en.s1),
		.words   (words),
		.geom_s1 (geom_s1)
	);

	// one lane per candidate axis
	for (genvar i = 0; i < orot_pkg::N_LANES; i++) begin : g_lane
		orot_lane u_lane (
			.clk     (clk),
			.en      (en),
			.geom_s1 (geom_s1),
			.axis_s1 (geom_s1.axis[i]),
			.hit_s6  (hits_s6[i])
		);
	end

	// lane verdicts into the output register
	orot_merge u_merge (
		.clk        (clk),
		.en         (en.out),
		.hits       (hits_s6),
		.collides_q (collides_q)
	);

	assign rsp.valid    = v_q[NS-1];
	assign rsp.collides = collides_q;

	// a full pipeline with a stalled output takes no new word
	`ORT_ASSERT_IMP(a_full_stall, (&v_q) && !rsp.ready, !req.ready, "full pipe accepted a word")
	// words in flight change only by what enters and leaves
	`ORT_ASSERT_NXT(a_conserve, 1'b1, ($countones(v_q) + $past(32'(rsp.valid && rsp.ready))) == ($past($countones(v_q)) + $past(32'(req.valid && req.ready))), "word lost or duplicated in pipe")
	// an empty idle pipe shows no result next cycle
	`ORT_ASSERT_NXT(a_no_phantom, (v_q == '0) && !req.valid, !rsp.valid, "result without a word")

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for the oriented rectangle overlap core
module testbench;

	localparam int CB = orot_pkg::COORD_BITS;

	// signed coordinate and edge component at the block's widths, projection one bit wider
	typedef logic signed [CB-1:0]   crd_t;
	typedef logic signed [CB:0]     span_t;
	typedef logic signed [2*CB+2:0] dot_t;

	typedef struct {
		crd_t x;
		crd_t y;
	} point_t;

	typedef struct {
		span_t x;
		span_t y;
	} dir_t;

	// four corner words of one rectangle
	typedef struct {
		orot_pkg::word_t c [4];
	} rect_words_t;

	// one directed row: both rectangles, and a typed-in answer where it is obvious
	typedef struct {
		rect_words_t a;
		rect_words_t b;
		bit          known;
		bit          collides;
	} pair_row_t;

	logic clk;
	logic arst_n;

	orot_in_if  req ();
	orot_out_if rsp ();

	oriented_rect_overlap_test_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// answers still owed by the block, oldest first
	bit          collides_due [$];
	int          mismatch_count;
	// typed-in answer that travels alongside the word on the bus
	bit          typed_known;
	bit          typed_value;
	// no random idling on either side while this is set
	bit          quiet_stretch;
	pair_row_t   directed_rows [$];
	rect_words_t seen_a;
	rect_words_t seen_b;

	// ---------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------

	// x sits in the low CB bits, y in the next CB bits; bits past the word read as zero
	function automatic point_t corner_of(orot_pkg::word_t w);
		logic [63:0] wide;
		point_t      p;
		wide = {32'b0, w};
		p.x  = crd_t'(wide[CB-1:0]);
		wide = wide >> CB;
		p.y  = crd_t'(wide[CB-1:0]);
		return p;
	endfunction

	// exact projection of a corner onto an axis
	function automatic dot_t project_onto(point_t p, dir_t d);
		return dot_t'(p.x) * dot_t'(d.x) + dot_t'(p.y) * dot_t'(d.y);
	endfunction

	// the side directions out of corner 0, with a zero-length side swapped
	// for the perpendicular of the other side (d0 toward corner 1, d1 toward corner 3)
	function automatic void edge_dirs(point_t p [4], output dir_t d0, output dir_t d1);
		d0.x = span_t'(p[1].x) - span_t'(p[0].x);
		d0.y = span_t'(p[1].y) - span_t'(p[0].y);
		d1.x = span_t'(p[3].x) - span_t'(p[0].x);
		d1.y = span_t'(p[3].y) - span_t'(p[0].y);
		if (d0.x == 0 && d0.y == 0) begin
			d0.x = -d1.y;
			d0.y = d1.x;
		end
		if (d1.x == 0 && d1.y == 0) begin
			d1.x = d0.y;
			d1.y = -d0.x;
		end
	endfunction

	// separating axis verdict: hit only when every axis shows a strict overlap
	function automatic bit sat_collides(rect_words_t ra, rect_words_t rb);
		point_t pa [4];
		point_t pb [4];
		dir_t   axes [4];
		dot_t   v;
		dot_t   amin, amax, bmin, bmax;
		bit     hit;
		for (int i = 0; i < 4; i++) begin
			pa[i] = corner_of(ra.c[i]);
			pb[i] = corner_of(rb.c[i]);
		end
		edge_dirs(pa, axes[0], axes[1]);
		edge_dirs(pb, axes[2], axes[3]);
		hit = 1'b1;
		for (int k = 0; k < 4; k++) begin
			amin = project_onto(pa[0], axes[k]);
			amax = amin;
			bmin = project_onto(pb[0], axes[k]);
			bmax = bmin;
			for (int j = 1; j < 4; j++) begin
				v = project_onto(pa[j], axes[k]);
				if (v < amin) amin = v;
				if (v > amax) amax = v;
				v = project_onto(pb[j], axes[k]);
				if (v < bmin) bmin = v;
				if (v > bmax) bmax = v;
			end
			// touching end points are a miss, containment is a hit
			if (!(amin < bmax && bmin < amax)) hit = 1'b0;
		end
		return hit;
	endfunction

	// ---------------------------------------------------------------------
	// shape builders
	// ---------------------------------------------------------------------

	// pack one corner, coordinates wrap to CB bits
	function automatic orot_pkg::word_t pack_xy(int x, int y);
		logic [63:0] mask;
		logic [63:0] w;
		mask = (64'd1 << CB) - 64'd1;
		w    = ((64'(y) & mask) << CB) | (64'(x) & mask);
		return w[31:0];
	endfunction

	// parallelogram from corner 0 and its side vectors, corners in walking order
	function automatic rect_words_t quad(int x0, int y0, int e0x, int e0y, int e1x, int e1y);
		rect_words_t r;
		r.c[0] = pack_xy(x0, y0);
		r.c[1] = pack_xy(x0 + e0x, y0 + e0y);
		r.c[2] = pack_xy(x0 + e0x + e1x, y0 + e0y + e1y);
		r.c[3] = pack_xy(x0 + e1x, y0 + e1y);
		return r;
	endfunction

	// random shape at a given corner 0: mostly near-rectangles at any angle,
	// some skewed, a few with a zero-length edge
	function automatic rect_words_t random_shape(int x0, int y0, int reach);
		int e0x, e0y, e1x, e1y;
		int kind;
		int scale;
		e0x   = int'($urandom_range(2 * reach)) - reach;
		e0y   = int'($urandom_range(2 * reach)) - reach;
		kind  = $urandom_range(19);
		scale = $urandom_range(1, 4);
		if (kind < 12) begin
			e1x = -e0y * scale / 2;
			e1y = e0x * scale / 2;
		end else begin
			e1x = int'($urandom_range(2 * reach)) - reach;
			e1y = int'($urandom_range(2 * reach)) - reach;
		end
		if (kind == 17) begin
			e0x = 0;
			e0y = 0;
		end else if (kind == 18) begin
			e1x = 0;
			e1y = 0;
		end else if (kind == 19) begin
			// point-like
			e0x = 0;
			e0y = 0;
			e1x = 0;
			e1y = 0;
		end
		return quad(x0, y0, e0x, e0y, e1x, e1y);
	endfunction

	function automatic rect_words_t raw_shape();
		rect_words_t r;
		for (int i = 0; i < 4; i++) r.c[i] = $urandom;
		return r;
	endfunction

	// random pair: mostly close neighbors so hits and misses both come up,
	// then shapes spread over the whole range, then raw words
	function automatic pair_row_t random_pair();
		pair_row_t row;
		int        sel;
		int        cx, cy;
		sel = $urandom_range(99);
		if (sel < 70) begin
			cx    = int'($urandom_range(400)) - 200;
			cy    = int'($urandom_range(400)) - 200;
			row.a = random_shape(cx, cy, 80);
			row.b = random_shape(cx + int'($urandom_range(300)) - 150,
				cy + int'($urandom_range(300)) - 150, 80);
		end else if (sel < 85) begin
			cx    = int'($urandom_range(60000)) - 30000;
			cy    = int'($urandom_range(60000)) - 30000;
			row.a = random_shape(cx, cy, 30000);
			row.b = random_shape(cx + int'($urandom_range(40000)) - 20000,
				cy + int'($urandom_range(40000)) - 20000, 30000);
		end else begin
			row.a = raw_shape();
			row.b = raw_shape();
		end
		row.known    = 1'b0;
		row.collides = 1'b0;
		return row;
	endfunction

	function automatic rect_words_t same_words(orot_pkg::word_t w0, orot_pkg::word_t w1,
		orot_pkg::word_t w2, orot_pkg::word_t w3);
		rect_words_t r;
		r.c[0] = w0;
		r.c[1] = w1;
		r.c[2] = w2;
		r.c[3] = w3;
		return r;
	endfunction

	task automatic add_row(rect_words_t ra, rect_words_t rb, bit known, bit collides);
		pair_row_t row;
		row.a        = ra;
		row.b        = rb;
		row.known    = known;
		row.collides = collides;
		directed_rows.push_back(row);
	endtask

	// ---------------------------------------------------------------------
	// clock and reset
	// ---------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------------------------------------------------------------
	// result side: random backpressure, off during the quiet stretch
	// ---------------------------------------------------------------------

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (quiet_stretch) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= ($urandom_range(99) >= 9);
			end
		end
	end

	// ---------------------------------------------------------------------
	// monitor: book the answer for each accepted word, then check results.
	// both handshakes are read right after the edge, before any register
	// of the block or bench takes its new value
	// ---------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				seen_a.c[0] = req.a_corner0;
				seen_a.c[1] = req.a_corner1;
				seen_a.c[2] = req.a_corner2;
				seen_a.c[3] = req.a_corner3;
				seen_b.c[0] = req.b_corner0;
				seen_b.c[1] = req.b_corner1;
				seen_b.c[2] = req.b_corner2;
				seen_b.c[3] = req.b_corner3;
				if (typed_known) begin
					collides_due.push_back(typed_value);
				end else begin
					collides_due.push_back(sat_collides(seen_a, seen_b));
				end
			end
			if (rsp.valid && rsp.ready) begin
				if (collides_due.size() == 0) begin
					$display("%0t: result word with nothing pending, collides %0b",
						$time, rsp.collides);
					mismatch_count++;
				end else begin
					if (rsp.collides !== collides_due[0]) begin
						$display("%0t: collides mismatch, expected %0b, actual %0b",
							$time, collides_due[0], rsp.collides);
						mismatch_count++;
					end
					void'(collides_due.pop_front());
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// sender
	// ---------------------------------------------------------------------

	// offer one word, with an occasional idle gap first, and hold it until taken
	task automatic offer_pair(pair_row_t row);
		while (!quiet_stretch && $urandom_range(99) < 9) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.a_corner0 <= row.a.c[0];
		req.a_corner1 <= row.a.c[1];
		req.a_corner2 <= row.a.c[2];
		req.a_corner3 <= row.a.c[3];
		req.b_corner0 <= row.b.c[0];
		req.b_corner1 <= row.b.c[1];
		req.b_corner2 <= row.b.c[2];
		req.b_corner3 <= row.b.c[3];
		typed_known   <= row.known;
		typed_value   <= row.collides;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	initial begin
		rect_words_t big_box;
		pair_row_t   row;
		int          guard;

		req.valid      = 1'b0;
		req.a_corner0  = '0;
		req.a_corner1  = '0;
		req.a_corner2  = '0;
		req.a_corner3  = '0;
		req.b_corner0  = '0;
		req.b_corner1  = '0;
		req.b_corner2  = '0;
		req.b_corner3  = '0;
		typed_known    = 1'b0;
		typed_value    = 1'b0;
		quiet_stretch  = 1'b0;
		mismatch_count = 0;

		// full-range square: corner 0 at the most negative point, edges span the range
		big_box = quad(-(1 << (CB - 1)), -(1 << (CB - 1)), (1 << CB) - 1, 0, 0, (1 << CB) - 1);

		// everything at the origin: point-like, no overlap possible
		add_row(same_words('0, '0, '0, '0), same_words('0, '0, '0, '0), 1'b1, 1'b0);
		// all ones: every corner is (-1,-1), point-like again
		add_row(same_words('1, '1, '1, '1), same_words('1, '1, '1, '1), 1'b1, 1'b0);
		// full-range square against itself
		add_row(big_box, big_box, 1'b1, 1'b1);
		// a rectangle always overlaps itself
		add_row(quad(5, -7, 40, 0, 0, 24), quad(5, -7, 40, 0, 0, 24), 1'b1, 1'b1);
		// first rectangle collapsed to a point with a stray corner 2
		add_row(same_words(pack_xy(3, 3), pack_xy(3, 3), pack_xy(90, 90), pack_xy(3, 3)),
			quad(0, 0, 64, 0, 0, 64), 1'b1, 1'b0);
		// most negative against most positive corners
		add_row(same_words(32'h8000_8000, 32'h7fff_8000, 32'h7fff_7fff, 32'h8000_7fff),
			same_words(32'h7fff_7fff, 32'h8000_7fff, 32'h8000_8000, 32'h7fff_8000), 1'b0, 1'b0);
		// full-range square with a small one at the origin
		add_row(big_box, quad(-8, -8, 16, 0, 0, 16), 1'b0, 1'b0);
		// plain overlap of two squares
		add_row(quad(0, 0, 32, 0, 0, 32), quad(16, 16, 32, 0, 0, 32), 1'b0, 1'b0);
		// edges touching only
		add_row(quad(0, 0, 32, 0, 0, 32), quad(32, 0, 32, 0, 0, 32), 1'b0, 1'b0);
		// corners touching only
		add_row(quad(0, 0, 32, 0, 0, 32), quad(32, 32, 32, 0, 0, 32), 1'b0, 1'b0);
		// one inside the other, both ways round
		add_row(quad(0, 0, 64, 0, 0, 64), quad(16, 16, 16, 0, 0, 16), 1'b0, 1'b0);
		add_row(quad(16, 16, 16, 0, 0, 16), quad(0, 0, 64, 0, 0, 64), 1'b0, 1'b0);
		// clear gap on one axis
		add_row(quad(0, 0, 32, 0, 0, 32), quad(100, 0, 32, 0, 0, 32), 1'b0, 1'b0);
		// diamond near a square's corner: once clear of it, once overlapping the corner
		add_row(quad(0, 0, 32, 0, 0, 32), quad(52, 40, 16, 16, -16, 16), 1'b0, 1'b0);
		add_row(quad(0, 0, 32, 0, 0, 32), quad(36, 20, 16, 16, -16, 16), 1'b0, 1'b0);
		// a zero-length e0 side, and a zero-length e1 side
		add_row(quad(0, 0, 0, 0, 48, 16), quad(10, -10, 24, 0, 0, 24), 1'b0, 1'b0);
		add_row(quad(0, 0, 48, 16, 0, 0), quad(10, -10, 24, 0, 0, 24), 1'b0, 1'b0);
		// zero-length edges on the second rectangle
		add_row(quad(0, 0, 40, 0, 0, 40), quad(20, 20, 0, 0, -30, 30), 1'b0, 1'b0);
		add_row(quad(0, 0, 40, 0, 0, 40), quad(60, 60, 30, 30, 0, 0), 1'b0, 1'b0);
		// skewed parallelograms
		add_row(quad(-20, 5, 50, 10, 15, 40), quad(30, 30, -25, 35, 40, 5), 1'b0, 1'b0);

		@(posedge clk);
		while (!arst_n) @(posedge clk);

		foreach (directed_rows[i]) offer_pair(directed_rows[i]);

		for (int n = 0; n < 1330; n++) begin
			// one long stretch with no idling at all
			quiet_stretch = (n >= 500 && n < 800);
			if (n == 300) begin
				// hold off until the pipeline has delivered everything
				req.valid <= 1'b0;
				@(posedge clk);
				while (collides_due.size() != 0) @(posedge clk);
			end
			row = random_pair();
			offer_pair(row);
		end
		req.valid <= 1'b0;
		quiet_stretch = 1'b0;

		// drain, then give the seven-stage pipe time to show any stray word
		guard = 0;
		while (collides_due.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (collides_due.size() != 0) begin
			$display("%0t: %0d result words never arrived", $time, collides_due.size());
			mismatch_count++;
		end

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
